// ===== rtl/core/rlrs_pkg.sv =====
`default_nettype none

package rlrs_pkg;

  localparam int unsigned LASER_W = 6;
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned DIFF_W  = 16;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 24;
  localparam int unsigned SUM_W   = RANGE_W + 3;

  localparam logic [ADDR_W-1:0] REG_SMOOTH_UPPER   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_SMOOTH_LOWER   = 3'd1;
  localparam logic [ADDR_W-1:0] REG_UPPER_MAX_DIFF = 3'd2;
  localparam logic [ADDR_W-1:0] REG_LOWER_MAX_DIFF = 3'd3;
  localparam logic [ADDR_W-1:0] REG_LASER_ENABLE   = 3'd4;
  localparam logic [ADDR_W-1:0] REG_MIN_RANGE      = 3'd5;

  localparam logic [DIFF_W-1:0]  RST_UPPER_MAX_DIFF = 16'd200;
  localparam logic [DIFF_W-1:0]  RST_LOWER_MAX_DIFF = 16'd0;
  localparam logic [MASK_W-1:0]  RST_LASER_ENABLE   = {MASK_W{1'b1}};
  localparam logic [RANGE_W-1:0] RST_MIN_RANGE      = 16'd100;

  // Division by 3 and 5 as multiply by reciprocal, exact for sums below 2^19.
  localparam int unsigned  DIV_SHIFT = 21;
  localparam int unsigned  MUL_W     = 20;
  localparam logic [MUL_W-1:0] DIV3_MUL = 20'd699051;
  localparam logic [MUL_W-1:0] DIV5_MUL = 20'd419431;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef struct packed {
    logic               smooth_upper;
    logic               smooth_lower;
    logic [DIFF_W-1:0]  upper_max_diff;
    logic [DIFF_W-1:0]  lower_max_diff;
    logic [MASK_W-1:0]  laser_enable;
    logic [RANGE_W-1:0] min_range;
  } cfg_t;

  typedef struct packed {
    logic [LASER_W-1:0] laser;
    logic [RANGE_W-1:0] r0;
    logic [RANGE_W-1:0] r1;
    logic [RANGE_W-1:0] r2;
    logic               valid;
  } held_job_t;

  typedef struct packed {
    logic [LASER_W-1:0] laser;
    logic [RANGE_W-1:0] range;
    logic               valid;
    logic               sweep_last;
    logic               run_end;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/rlrs_calc.sv =====
`default_nettype none

module rlrs_calc (
  input  wire rlrs_pkg::cfg_t      cfg,
  input  wire rlrs_pkg::held_job_t job,
  output rlrs_pkg::result_t        res
);

  logic                                    upper;
  logic                                    on;
  logic [rlrs_pkg::DIFF_W-1:0]             lim;
  logic [rlrs_pkg::RANGE_W-1:0]            d10;
  logic [rlrs_pkg::RANGE_W-1:0]            d21;
  logic                                    gate;
  logic                                    enabled;
  logic [rlrs_pkg::SUM_W-1:0]              sum3;
  logic [rlrs_pkg::SUM_W-1:0]              sum5;
  logic [rlrs_pkg::SUM_W-1:0]              dividend;
  logic [rlrs_pkg::MUL_W-1:0]              recip;
  logic [rlrs_pkg::SUM_W+rlrs_pkg::MUL_W-1:0] prod;
  logic [rlrs_pkg::RANGE_W-1:0]            quot;

  always_comb begin
    upper   = ~job.laser[rlrs_pkg::LASER_W-1];
    on      = upper ? cfg.smooth_upper : cfg.smooth_lower;
    lim     = upper ? cfg.upper_max_diff : cfg.lower_max_diff;
    d10     = (job.r1 > job.r0) ? (job.r1 - job.r0) : (job.r0 - job.r1);
    d21     = (job.r2 > job.r1) ? (job.r2 - job.r1) : (job.r1 - job.r2);
    gate    = (job.r1 > cfg.min_range) && (d10 < lim) && (d21 < lim);
    enabled = cfg.laser_enable[job.laser];

    sum3 = rlrs_pkg::SUM_W'(job.r0) + rlrs_pkg::SUM_W'(job.r1) + rlrs_pkg::SUM_W'(job.r2);
    sum5 = rlrs_pkg::SUM_W'(job.r0) + rlrs_pkg::SUM_W'({job.r1, 1'b0})
         + rlrs_pkg::SUM_W'(job.r1) + rlrs_pkg::SUM_W'(job.r2);
    dividend = upper ? sum3 : sum5;
    recip    = upper ? rlrs_pkg::DIV3_MUL : rlrs_pkg::DIV5_MUL;
    prod     = (rlrs_pkg::SUM_W+rlrs_pkg::MUL_W)'(dividend)
             * (rlrs_pkg::SUM_W+rlrs_pkg::MUL_W)'(recip);
    quot     = prod[rlrs_pkg::DIV_SHIFT +: rlrs_pkg::RANGE_W];

    res.laser      = job.laser;
    res.range      = (on && gate) ? quot : job.r1;
    res.valid      = on ? (job.valid & enabled & gate) : job.valid;
    res.sweep_last = 1'b0;
    res.run_end    = 1'b0;
  end

endmodule

`default_nettype wire

// ===== rtl/core/lidar_ring_range_smoother_top.sv =====
`default_nettype none

// Lidar ring range smoother. Input words carry one lidar return each; the
// sweep's first mark travels on in_tuser and its last mark on in_tlast.
// Interior points of a sweep are smoothed with their two stream neighbors
// and leave when the right neighbor arrives; first and last points pass
// through unchanged. One input word yields zero, one or two output words,
// and out_tuser marks the final output word caused by an input word.
// A word is accepted in any cycle while the output queue has room for two
// results, so one word per cycle is sustained as long as each word causes
// at most one result and the receiver keeps out_tready high; a word with
// two results leaves two words for the receiver to take. A result passes
// through the job register into the output queue before it is presented.
// When the receiver stalls, the four-entry output queue fills and in_tready
// drops once fewer than two slots remain, counting results still in the job
// register. Synchronous reset clears the sweep state, the queue and restores
// the register defaults. Configuration writes take effect at the next edge;
// the user must make them only while the block is idle, which the block
// itself does not enforce.
module lidar_ring_range_smoother_top (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [rlrs_pkg::DATA_W-1:0] in_tdata,   // laser[5:0], range_cm[21:6], valid_in[22], zero[23]
  input  wire        in_tuser,   // sweep_first
  input  wire        in_tlast,   // sweep_last
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [rlrs_pkg::DATA_W-1:0] out_tdata, // out_laser[5:0], out_range[21:6], out_valid[22], zero[23]
  output logic       out_tuser,  // run_end
  output logic       out_tlast,  // out_sweep_last
  input  wire        cfg_we,
  input  wire [rlrs_pkg::ADDR_W-1:0] cfg_addr,
  input  wire [rlrs_pkg::CFG_W-1:0]  cfg_wdata
);

  rlrs_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smooth_upper   <= 1'b1;
      cfg_r.smooth_lower   <= 1'b1;
      cfg_r.upper_max_diff <= rlrs_pkg::RST_UPPER_MAX_DIFF;
      cfg_r.lower_max_diff <= rlrs_pkg::RST_LOWER_MAX_DIFF;
      cfg_r.laser_enable   <= rlrs_pkg::RST_LASER_ENABLE;
      cfg_r.min_range      <= rlrs_pkg::RST_MIN_RANGE;
    end else if (cfg_we) begin
      case (cfg_addr)
        rlrs_pkg::REG_SMOOTH_UPPER:   cfg_r.smooth_upper   <= cfg_wdata[0];
        rlrs_pkg::REG_SMOOTH_LOWER:   cfg_r.smooth_lower   <= cfg_wdata[0];
        rlrs_pkg::REG_UPPER_MAX_DIFF: cfg_r.upper_max_diff <= cfg_wdata[rlrs_pkg::DIFF_W-1:0];
        rlrs_pkg::REG_LOWER_MAX_DIFF: cfg_r.lower_max_diff <= cfg_wdata[rlrs_pkg::DIFF_W-1:0];
        rlrs_pkg::REG_LASER_ENABLE:   cfg_r.laser_enable   <= cfg_wdata;
        rlrs_pkg::REG_MIN_RANGE:      cfg_r.min_range      <= cfg_wdata[rlrs_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input word fields.
  logic [rlrs_pkg::LASER_W-1:0] in_laser;
  logic [rlrs_pkg::RANGE_W-1:0] in_range;
  logic                         in_valid;
  logic                         accept;

  assign in_laser = in_tdata[5:0];
  assign in_range = in_tdata[21:6];
  assign in_valid = in_tdata[22];
  assign accept   = in_tvalid && in_tready;

  // Sweep state.
  logic [rlrs_pkg::RANGE_W-1:0] prev_range_r, prev_range_nxt;
  logic [rlrs_pkg::RANGE_W-1:0] held_range_r, held_range_nxt;
  logic [rlrs_pkg::LASER_W-1:0] held_laser_r, held_laser_nxt;
  logic                         held_valid_r, held_valid_nxt;
  logic                         held_present_r, held_present_nxt;
  logic                         sweep_open_r, sweep_open_nxt;

  // Job register between acceptance and the output queue.
  logic                  job_a_r, job_a_nxt;
  logic                  job_b_r, job_b_nxt;
  logic                  job_smooth_r, job_smooth_nxt;
  rlrs_pkg::held_job_t   job_held_r, job_held_nxt;
  rlrs_pkg::result_t     job_in_r, job_in_nxt;

  always_comb begin
    prev_range_nxt   = prev_range_r;
    held_range_nxt   = held_range_r;
    held_laser_nxt   = held_laser_r;
    held_valid_nxt   = held_valid_r;
    held_present_nxt = held_present_r;
    sweep_open_nxt   = sweep_open_r;
    job_a_nxt        = 1'b0;
    job_b_nxt        = 1'b0;
    job_smooth_nxt   = job_smooth_r;
    job_held_nxt     = job_held_r;
    job_in_nxt       = job_in_r;

    if (accept) begin
      job_held_nxt.laser = held_laser_r;
      job_held_nxt.r0    = prev_range_r;
      job_held_nxt.r1    = held_range_r;
      job_held_nxt.r2    = in_range;
      job_held_nxt.valid = held_valid_r;

      job_in_nxt.laser      = in_laser;
      job_in_nxt.range      = in_range;
      job_in_nxt.valid      = in_valid;
      job_in_nxt.sweep_last = in_tlast;
      job_in_nxt.run_end    = 1'b1;

      job_a_nxt = held_present_r;

      if (in_tuser || !sweep_open_r) begin
        // A new sweep flushes any held point unchanged.
        job_smooth_nxt   = 1'b0;
        job_b_nxt        = 1'b1;
        held_present_nxt = 1'b0;
        sweep_open_nxt   = !in_tlast;
        prev_range_nxt   = in_range;
      end else if (in_tlast) begin
        job_smooth_nxt   = 1'b1;
        job_b_nxt        = 1'b1;
        held_present_nxt = 1'b0;
        sweep_open_nxt   = 1'b0;
        prev_range_nxt   = in_range;
      end else begin
        job_smooth_nxt   = 1'b1;
        if (held_present_r) begin
          prev_range_nxt = held_range_r;
        end
        held_range_nxt   = in_range;
        held_laser_nxt   = in_laser;
        held_valid_nxt   = in_valid;
        held_present_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_range_r   <= '0;
      held_range_r   <= '0;
      held_laser_r   <= '0;
      held_valid_r   <= 1'b0;
      held_present_r <= 1'b0;
      sweep_open_r   <= 1'b0;
      job_a_r        <= 1'b0;
      job_b_r        <= 1'b0;
    end else begin
      prev_range_r   <= prev_range_nxt;
      held_range_r   <= held_range_nxt;
      held_laser_r   <= held_laser_nxt;
      held_valid_r   <= held_valid_nxt;
      held_present_r <= held_present_nxt;
      sweep_open_r   <= sweep_open_nxt;
      job_a_r        <= job_a_nxt;
      job_b_r        <= job_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_smooth_r <= job_smooth_nxt;
    job_held_r   <= job_held_nxt;
    job_in_r     <= job_in_nxt;
  end

  // Smoothing of the held point.
  rlrs_pkg::result_t calc_res;

  rlrs_calc u_calc (
    .cfg (cfg_r),
    .job (job_held_r),
    .res (calc_res)
  );

  rlrs_pkg::result_t res_a;
  rlrs_pkg::result_t wr_first;
  logic [1:0]        push_n;

  always_comb begin
    if (job_smooth_r) begin
      res_a = calc_res;
    end else begin
      res_a.laser      = job_held_r.laser;
      res_a.range      = job_held_r.r1;
      res_a.valid      = job_held_r.valid;
      res_a.sweep_last = 1'b1;
      res_a.run_end    = 1'b0;
    end
    res_a.run_end = !job_b_r;
    wr_first      = job_a_r ? res_a : job_in_r;
    push_n        = {1'b0, job_a_r} + {1'b0, job_b_r};
  end

  // Output queue.
  rlrs_pkg::result_t           fifo_r [rlrs_pkg::FIFO_DEPTH];
  logic [rlrs_pkg::PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [rlrs_pkg::PTR_W-1:0]  wr_ptr_p1;
  logic [rlrs_pkg::CNT_W-1:0]  cnt_r;
  logic [rlrs_pkg::CNT_W-1:0]  occ_r;
  logic                        pop;
  logic [rlrs_pkg::CNT_W-1:0]  accept_n;

  assign wr_ptr_p1 = wr_ptr_r + rlrs_pkg::PTR_W'(1);
  assign pop       = out_tvalid && out_tready;
  assign accept_n  = accept ? rlrs_pkg::CNT_W'({1'b0, held_present_r} + {1'b0, job_b_nxt})
                            : '0;

  always_ff @(posedge clk) begin
    for (int i = 0; i < rlrs_pkg::FIFO_DEPTH; i++) begin
      if (push_n != 2'd0 && wr_ptr_r == rlrs_pkg::PTR_W'(i)) begin
        fifo_r[i] <= wr_first;
      end
      if (push_n == 2'd2 && wr_ptr_p1 == rlrs_pkg::PTR_W'(i)) begin
        fifo_r[i] <= job_in_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      occ_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + rlrs_pkg::PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + rlrs_pkg::PTR_W'(pop);
      cnt_r    <= cnt_r + rlrs_pkg::CNT_W'(push_n) - rlrs_pkg::CNT_W'(pop);
      occ_r    <= occ_r + accept_n - rlrs_pkg::CNT_W'(pop);
    end
  end

  // Occupancy counts results in the job register and in the queue.
  assign in_tready  = occ_r <= rlrs_pkg::CNT_W'(rlrs_pkg::FIFO_DEPTH - 2);
  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = {1'b0, fifo_r[rd_ptr_r].valid, fifo_r[rd_ptr_r].range,
                       fifo_r[rd_ptr_r].laser};
  assign out_tuser  = fifo_r[rd_ptr_r].run_end;
  assign out_tlast  = fifo_r[rd_ptr_r].sweep_last;

endmodule

`default_nettype wire
